// ----- rtl/pngu_pkg.sv -----
// Shared types and constants for the PNG scanline unfilter.
// No dependencies; the top level, recon, checker and testbench import it.
`default_nettype none

package pngu_pkg;

   localparam int BYTE_W     = 8;
   localparam int ROW_REG_W  = 15;
   localparam int BPP_REG_W  = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 15;

   // Register map of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_BYTES   = 1'b0,
      REG_PIXEL_BYTES = 1'b1
   } csr_reg_type;

   // PNG filter types as carried in the filter byte
   typedef enum logic [2:0] {
      FILT_NONE    = 3'd0,
      FILT_SUB     = 3'd1,
      FILT_UP      = 3'd2,
      FILT_AVERAGE = 3'd3,
      FILT_PAETH   = 3'd4
   } filter_type;

   // Neighbor bytes of the current column: left, above, upper-left
   typedef struct packed {
      logic [BYTE_W-1:0] a;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] c;
   } nbr_type;

endpackage

`default_nettype wire

// ----- rtl/png_scanline_unfilter.sv -----
// Top level of the PNG scanline unfilter: input register, row state,
// line store and result register. Depends on pngu_pkg, pngu_ram, pngu_recon.
//
//   channel   direction  handshake           words
//   req_      in         req_valid/req_stall data_byte, image_start
//   rsp_      out        rsp_valid/rsp_stall pixel_byte, row_last
//   csr_      in         csr_valid/csr_ready index, data (ready always high)
//
// One word a cycle sustained while no held result stalls the input. A word
// sits in the input register while the reconstruction runs, and the result
// register takes the pixel when the word advances, which is when rsp_valid
// rises. The line store read for the next column is issued ahead, from the
// next-column value.
// Reset clears all control state and the left/upper-left windows; the line
// store needs no clearing. req_stall rises only while a result is held by
// rsp_stall and the input register holds a data word.
`default_nettype none

module png_scanline_unfilter
   import pngu_pkg::*;
#(
   parameter int MAX_ROW_BYTES   = 16384,
   parameter int MAX_PIXEL_BYTES = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [BYTE_W-1:0]     req_data_byte,
   input  wire logic                  req_image_start,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [BYTE_W-1:0]     rsp_pixel_byte,
   output logic                       rsp_row_last,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int RB_W   = $clog2(MAX_ROW_BYTES + 1);
   localparam int CMP_W  = (RB_W > ROW_REG_W) ? RB_W : ROW_REG_W;
   localparam int SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam int BPP_W  = $clog2(MAX_PIXEL_BYTES + 1);
   localparam int XW     = (ADDR_W > BPP_W) ? ADDR_W : BPP_W;

   // configuration
   logic [ROW_REG_W-1:0] row_bytes_ff;
   logic [BPP_REG_W-1:0] bpp_ff;
   logic [CMP_W-1:0]     rb_wide;
   logic [RB_W-1:0]      eff_rb;
   logic [BPP_W-1:0]     eff_bpp;

   // input register
   logic              s1_valid_ff;
   logic [BYTE_W-1:0] s1_data_ff;
   logic              s1_start_ff;

   // row state
   logic [ADDR_W-1:0] column_ff, column_in;
   filter_type        kind_ff, kind_in, kind_dec;
   logic              await_ff, await_in;
   logic              first_row_ff, first_row_in;
   logic [SLOT_W-1:0] slot_ff [MAX_PIXEL_BYTES];
   logic [BYTE_W-1:0] left_ff [MAX_PIXEL_BYTES];
   logic [BYTE_W-1:0] upl_ff  [MAX_PIXEL_BYTES];
   logic              slot_clr;
   logic              slot_inc;
   logic [SLOT_W-1:0] slot;

   // line store read path with same-address bypass
   logic [BYTE_W-1:0] ram_rd;
   logic              byp_ff, byp_in;
   logic [BYTE_W-1:0] byp_data_ff;
   logic [BYTE_W-1:0] above_raw;

   // step control
   logic              has_result;
   logic              advance;
   logic              data_step;
   logic              filt_step;
   logic              has_left;
   logic              row_end;
   logic [ADDR_W:0]   x_inc;
   nbr_type           nbr;
   logic [BYTE_W-1:0] val;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] pixel_ff;
   logic              last_ff;

   // Clamp the registers to their usable ranges
   always_comb begin
      rb_wide = CMP_W'(row_bytes_ff);
      if (rb_wide == '0) begin
         eff_rb = RB_W'(1);
      end else if (rb_wide > CMP_W'(MAX_ROW_BYTES)) begin
         eff_rb = RB_W'(MAX_ROW_BYTES);
      end else begin
         eff_rb = RB_W'(rb_wide);
      end
      if (bpp_ff == '0) begin
         eff_bpp = BPP_W'(1);
      end else if (32'(bpp_ff) > 32'(MAX_PIXEL_BYTES)) begin
         eff_bpp = BPP_W'(MAX_PIXEL_BYTES);
      end else begin
         eff_bpp = BPP_W'(bpp_ff);
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= ROW_REG_W'(1);
         bpp_ff       <= BPP_REG_W'(1);
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_ROW_BYTES:   row_bytes_ff <= csr_data[ROW_REG_W-1:0];
            REG_PIXEL_BYTES: bpp_ff       <= csr_data[BPP_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Filter words never produce a result, so they always drain
   assign has_result = s1_valid_ff && !s1_start_ff && !await_ff;
   assign advance    = s1_valid_ff && (!has_result || !rsp_valid_ff || !rsp_stall);
   assign data_step  = advance && has_result;
   assign filt_step  = advance && !has_result;
   assign req_stall  = s1_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff  <= req_data_byte;
         s1_start_ff <= req_image_start;
      end
   end

   // Unknown filter types fall back to None
   always_comb begin
      case (s1_data_ff)
         BYTE_W'(FILT_SUB):     kind_dec = FILT_SUB;
         BYTE_W'(FILT_UP):      kind_dec = FILT_UP;
         BYTE_W'(FILT_AVERAGE): kind_dec = FILT_AVERAGE;
         BYTE_W'(FILT_PAETH):   kind_dec = FILT_PAETH;
         default:               kind_dec = FILT_NONE;
      endcase
   end

   // Column mod bpp comes from one wrap counter per possible bpp
   assign slot     = slot_ff[SLOT_W'(eff_bpp - BPP_W'(1))];
   assign has_left = XW'(column_ff) >= XW'(eff_bpp);
   assign x_inc    = {1'b0, column_ff} + (ADDR_W + 1)'(1);
   assign row_end  = x_inc >= (ADDR_W + 1)'(eff_rb);

   assign above_raw = byp_ff ? byp_data_ff : ram_rd;
   assign nbr.a = has_left ? left_ff[slot] : '0;
   assign nbr.b = first_row_ff ? '0 : above_raw;
   assign nbr.c = (!first_row_ff && has_left) ? upl_ff[slot] : '0;

   pngu_recon u_recon (
      .kind       (kind_ff),
      .data_byte  (s1_data_ff),
      .nbr        (nbr),
      .pixel_byte (val)
   );

   always_comb begin
      column_in    = column_ff;
      kind_in      = kind_ff;
      await_in     = await_ff;
      first_row_in = first_row_ff;
      slot_clr     = 1'b0;
      slot_inc     = 1'b0;
      if (filt_step) begin
         // image start abandons the row and restarts at the first row
         column_in = '0;
         kind_in   = kind_dec;
         await_in  = 1'b0;
         slot_clr  = 1'b1;
         if (s1_start_ff) begin
            first_row_in = 1'b1;
         end
      end else if (data_step) begin
         if (row_end) begin
            column_in    = '0;
            await_in     = 1'b1;
            first_row_in = 1'b0;
            slot_clr     = 1'b1;
         end else begin
            column_in = x_inc[ADDR_W-1:0];
            slot_inc  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         kind_ff      <= FILT_NONE;
         await_ff     <= 1'b1;
         first_row_ff <= 1'b1;
         for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            slot_ff[i] <= '0;
            left_ff[i] <= '0;
            upl_ff[i]  <= '0;
         end
      end else begin
         column_ff    <= column_in;
         kind_ff      <= kind_in;
         await_ff     <= await_in;
         first_row_ff <= first_row_in;
         for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            if (slot_clr) begin
               slot_ff[i] <= '0;
            end else if (slot_inc) begin
               slot_ff[i] <= (slot_ff[i] == SLOT_W'(i)) ? '0 : slot_ff[i] + SLOT_W'(1);
            end
         end
         if (data_step) begin
            left_ff[slot] <= val;
            upl_ff[slot]  <= nbr.b;
         end
      end
   end

   // Prefetch the above byte for the next column; forward a same-cycle write
   assign byp_in = data_step && (column_ff == column_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= val;
   end

   pngu_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_ROW_BYTES)
   ) u_prior_row (
      .clock   (clock),
      .wr_en   (data_step),
      .wr_addr (column_ff),
      .wr_data (val),
      .rd_addr (column_in),
      .rd_data (ram_rd)
   );

   // Hold the result until taken; load a new one on a data step
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (data_step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (data_step) begin
         pixel_ff <= val;
         last_ff  <= row_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = pixel_ff;
   assign rsp_row_last   = last_ff;

endmodule

`default_nettype wire

// ----- rtl/pngu_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pngu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                   wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                   rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/pngu_recon.sv -----
// Byte reconstruction for the five PNG filter types, including the Paeth pick.
// Depends on pngu_pkg for the filter codes and the neighbor struct.
`default_nettype none

module pngu_recon
   import pngu_pkg::*;
(
   input  wire filter_type        kind,
   input  wire logic [BYTE_W-1:0] data_byte,
   input  wire nbr_type           nbr,
   output logic      [BYTE_W-1:0] pixel_byte
);

   function automatic logic [BYTE_W:0] abs10(input logic signed [BYTE_W+1:0] v);
      logic signed [BYTE_W+1:0] n;
      n = -v;
      return v[BYTE_W+1] ? n[BYTE_W:0] : v[BYTE_W:0];
   endfunction

   logic signed [BYTE_W+1:0] diff_bc;
   logic signed [BYTE_W+1:0] diff_ac;
   logic signed [BYTE_W+1:0] diff_abc;
   logic        [BYTE_W:0]   pa;
   logic        [BYTE_W:0]   pb;
   logic        [BYTE_W:0]   pc;
   logic        [BYTE_W:0]   avg_sum;
   logic        [BYTE_W-1:0] paeth;
   logic        [BYTE_W-1:0] pred;

   // p = a + b - c, so |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
   always_comb begin
      diff_bc  = $signed({2'b00, nbr.b}) - $signed({2'b00, nbr.c});
      diff_ac  = $signed({2'b00, nbr.a}) - $signed({2'b00, nbr.c});
      diff_abc = $signed({2'b00, nbr.a}) + $signed({2'b00, nbr.b})
               - $signed({1'b0, nbr.c, 1'b0});
      pa = abs10(diff_bc);
      pb = abs10(diff_ac);
      pc = abs10(diff_abc);
      if (pa <= pb && pa <= pc) begin
         paeth = nbr.a;
      end else if (pb <= pc) begin
         paeth = nbr.b;
      end else begin
         paeth = nbr.c;
      end
      avg_sum = {1'b0, nbr.a} + {1'b0, nbr.b};
   end

   always_comb begin
      case (kind)
         FILT_SUB:     pred = nbr.a;
         FILT_UP:      pred = nbr.b;
         FILT_AVERAGE: pred = avg_sum[BYTE_W:1];
         FILT_PAETH:   pred = paeth;
         default:      pred = '0;
      endcase
      pixel_byte = data_byte + pred;
   end

endmodule

`default_nettype wire

// ----- rtl/pngu_checker.sv -----
// Port-level checks for the PNG scanline unfilter, bound to its top level.
// Depends on pngu_pkg for the byte width.
`default_nettype none

module pngu_checker
   import pngu_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [BYTE_W-1:0] rsp_pixel_byte,
   input wire logic              rsp_row_last
);

   // A held result keeps its word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_byte)
                                 && $stable(rsp_row_last))
      else $error("held result changed");

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Input backpressure only comes from a blocked result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with output free");

   // A new result follows an accepted word via the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching input word");

endmodule

bind png_scanline_unfilter pngu_checker u_pngu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_pixel_byte (rsp_pixel_byte),
   .rsp_row_last   (rsp_row_last)
);

`default_nettype wire

// ----- sim/tb_png_scanline_unfilter.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for png_scanline_unfilter: PNG filter reconstruction
// of a byte stream, checked against an in-bench predictor. Depends on pngu_pkg.

module tb_png_scanline_unfilter;
   import pngu_pkg::*;

   localparam int LINE_MAX       = 16384;   // widest row the block keeps
   localparam int PIXEL_MAX      = 8;       // widest filter distance
   localparam int DRAIN_CYCLES   = 4;       // covers the input and result registers
   localparam int WATCHDOG_LIMIT = 2000;    // cycles with no word moving
   localparam int LONG_ROW_WORDS = 300;     // data words sent on a clamped row
   localparam int ITEM_TARGET    = 1700;    // input words for the whole run

   // One reconstructed word as the result channel carries it
   typedef struct packed {
      logic [BYTE_W-1:0] pixel_byte;
      logic              row_last;
   } pixel_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_data_byte = '0;
   logic                  req_image_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BYTE_W-1:0]     rsp_pixel_byte;
   logic                  rsp_row_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = REG_ROW_BYTES;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   png_scanline_unfilter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_image_start (req_image_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_byte  (rsp_pixel_byte),
      .rsp_row_last    (rsp_row_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Unfilter predictor: its own copy of the registers, line store and
   // neighbor windows, advanced once per accepted input word.
   // ---------------------------------------------------------------------
   logic [ROW_REG_W-1:0] row_bytes_reg = 15'd1;
   logic [BPP_REG_W-1:0] pixel_bytes_reg = 4'd1;
   logic [BYTE_W-1:0]    line_store [LINE_MAX];
   logic [BYTE_W-1:0]    left_win [PIXEL_MAX] = '{default: '0};
   logic [BYTE_W-1:0]    upleft_win [PIXEL_MAX] = '{default: '0};
   int unsigned          cur_col = 0;
   filter_type           cur_filter = FILT_NONE;
   bit                   want_filter = 1'b1;
   bit                   in_first_row = 1'b1;
   // columns of the line store written since the current image began;
   // a later row must never read past this
   int unsigned          image_span = 0;

   pixel_word_type pending_pixels [$];
   int unsigned mismatches = 0;
   int unsigned sent_words = 0;
   bit          steady_flow = 1'b0;   // suppress idling on both sides

   // Row length actually in force: zero acts as one, large values clamp
   function automatic int unsigned row_len();
      if (row_bytes_reg == 0) return 1;
      if (row_bytes_reg > LINE_MAX) return LINE_MAX;
      return row_bytes_reg;
   endfunction

   function automatic void unfilter_word(input logic [BYTE_W-1:0] d, input logic start);
      int unsigned pix_dist, x, slot;
      int          a, b, c, p, pa, pb, pc, pick;
      logic [BYTE_W-1:0] val;
      pixel_word_type w;
      if (start) begin
         in_first_row = 1'b1;
         want_filter  = 1'b1;
         cur_col      = 0;
         image_span   = 0;
      end
      // filter byte: latch the type, unknown types fall back to None
      if (want_filter) begin
         cur_filter  = (d <= 8'(FILT_PAETH)) ? filter_type'(d[2:0]) : FILT_NONE;
         want_filter = 1'b0;
         cur_col     = 0;
         return;
      end
      pix_dist = (pixel_bytes_reg == 0) ? 1 :
                 (pixel_bytes_reg > PIXEL_MAX) ? PIXEL_MAX : pixel_bytes_reg;
      x    = (cur_col >= LINE_MAX) ? LINE_MAX - 1 : cur_col;
      slot = x % pix_dist;
      a = (x >= pix_dist) ? int'(left_win[slot]) : 0;
      b = in_first_row ? 0 : int'(line_store[x]);
      c = (!in_first_row && x >= pix_dist) ? int'(upleft_win[slot]) : 0;
      case (cur_filter)
         FILT_SUB:     val = 8'(int'(d) + a);
         FILT_UP:      val = 8'(int'(d) + b);
         FILT_AVERAGE: val = 8'(int'(d) + ((a + b) >> 1));
         FILT_PAETH: begin
            p  = a + b - c;
            pa = (p > a) ? p - a : a - p;
            pb = (p > b) ? p - b : b - p;
            pc = (p > c) ? p - c : c - p;
            if (pa <= pb && pa <= pc) pick = a;
            else if (pb <= pc) pick = b;
            else pick = c;
            val = 8'(int'(d) + pick);
         end
         default:      val = d;
      endcase
      left_win[slot]   = val;
      upleft_win[slot] = 8'(b);
      line_store[x]    = val;
      if (x + 1 > image_span) image_span = x + 1;
      w.pixel_byte = val;
      if (x + 1 >= row_len()) begin
         w.row_last   = 1'b1;
         cur_col      = 0;
         want_filter  = 1'b1;
         in_first_row = 1'b0;
      end else begin
         w.row_last = 1'b0;
         cur_col    = x + 1;
      end
      pending_pixels.push_back(w);
   endfunction

   // ---------------------------------------------------------------------
   // Idling: mostly none or short, now and then a long stretch
   // ---------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_filter();
      if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, 4));
      return 8'($urandom_range(5, 255));
   endfunction

   // Data bytes lean toward the extremes so wraparound is hit often
   function automatic logic [BYTE_W-1:0] pick_data();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // Receiver: stall for a random run, then free for one cycle
   initial begin : rsp_stall_drive
      int unsigned run;
      forever begin
         run = pick_gap();
         repeat (run) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: every accepted word against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_word_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel_byte %02h row_last %0b arrived with nothing expected",
                   rsp_pixel_byte, rsp_row_last);
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_byte !== want.pixel_byte) begin
               $error("pixel_byte: expected %02h, got %02h", want.pixel_byte,
                      rsp_pixel_byte);
               mismatches++;
            end
            if (rsp_row_last !== want.row_last) begin
               $error("row_last: expected %0b, got %0b", want.row_last, rsp_row_last);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: end the run when no word moves on any channel for too long
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Send one word after a random gap; hold it until the block takes it
   task automatic send_word(input logic [BYTE_W-1:0] value, input logic new_image);
      int unsigned gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_data_byte   <= value;
      req_image_start <= new_image;
      do @(posedge clock); while (req_stall);
      unfilter_word(value, new_image);
      sent_words++;
   endtask

   // Drop valid and wait until every expected pixel is back. A filter byte
   // gives no pixel, so let the pipeline settle for DRAIN_CYCLES more.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register, only once the block has gone idle
   task automatic write_csr(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_ROW_BYTES) row_bytes_reg = value[ROW_REG_W-1:0];
      else pixel_bytes_reg = value[BPP_REG_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // One two-byte row per filter type, extreme bytes, unknown type as None
   task automatic test_filter_types();
      logic [BYTE_W-1:0] kinds [6];
      logic [BYTE_W-1:0] bytes [12];
      kinds = '{8'(FILT_NONE), 8'(FILT_SUB), 8'(FILT_UP), 8'(FILT_AVERAGE),
                8'(FILT_PAETH), 8'd5};
      bytes = '{8'hFF, 8'h00, 8'h01, 8'hFF, 8'h80, 8'h7F,
                8'hFF, 8'hFF, 8'h00, 8'h80, 8'hAA, 8'h55};
      write_csr(REG_ROW_BYTES, 15'd2);
      // upper bits of the write are ignored by the 4-bit register
      write_csr(REG_PIXEL_BYTES, 15'h7FF1);
      for (int r = 0; r < 6; r++) begin
         send_word(kinds[r], r == 0);
         send_word(bytes[2*r], 1'b0);
         send_word(bytes[2*r+1], 1'b0);
      end
   endtask

   // Image start on a data byte: abandon the row and begin a new image,
   // whose filter byte is the top unknown type
   task automatic test_image_restart();
      send_word(8'(FILT_SUB), 1'b0);
      send_word(8'h33, 1'b0);
      send_word(8'hFF, 1'b1);
      send_word(8'h5A, 1'b0);
      send_word(8'hA5, 1'b0);
   endtask

   // Shrink the row past the current column mid-row: the next byte ends it
   task automatic test_mid_row_shrink();
      write_csr(REG_ROW_BYTES, 15'd4);
      send_word(8'(FILT_PAETH), 1'b1);
      repeat (3) send_word(pick_data(), 1'b0);
      write_csr(REG_ROW_BYTES, 15'd2);
      write_csr(REG_PIXEL_BYTES, 15'd3);
      send_word(pick_data(), 1'b0);
   endtask

   // Largest register values clamp to the full line store and pixel width:
   // a long row runs on without ending, then a new image abandons it
   task automatic test_longest_row();
      write_csr(REG_ROW_BYTES, 15'h7FFF);
      write_csr(REG_PIXEL_BYTES, 15'h000F);
      steady_flow = 1'b1;
      send_word(8'(FILT_SUB), 1'b1);
      repeat (LONG_ROW_WORDS) send_word(pick_data(), 1'b0);
      send_word(8'(FILT_PAETH), 1'b1);
      steady_flow = 1'b0;
   endtask

   // Phases of random settings, each a run of mostly well-formed rows with
   // random content, some stray image starts and rows left open mid-way
   task automatic test_random_streams();
      int unsigned stop_at, phase_words, k, len;
      logic [BYTE_W-1:0] value;
      logic              start;
      stop_at = ITEM_TARGET;
      while (sent_words < stop_at) begin
         if ($urandom_range(0, 1)) begin
            k = $urandom_range(0, 99);
            if (k < 8) len = 0;
            else if (k < 55) len = $urandom_range(1, 8);
            else if (k < 88) len = $urandom_range(9, 40);
            else len = $urandom_range(41, 200);
            write_csr(REG_ROW_BYTES, 15'(len));
         end
         if ($urandom_range(0, 1))
            write_csr(REG_PIXEL_BYTES, {11'($urandom), 4'($urandom_range(0, 15))});
         steady_flow = ($urandom_range(0, 5) == 0);
         phase_words = $urandom_range(1, 4) * (row_len() + 1);
         // now and then leave a row open so the next settings land mid-row
         if ($urandom_range(0, 3) == 0) phase_words += $urandom_range(1, row_len());
         for (int i = 0; i < phase_words && sent_words < stop_at; i++) begin
            start = (i == 0 && $urandom_range(0, 3) == 0) || ($urandom_range(0, 99) < 2);
            // a grown row would read line store entries this image never
            // wrote: open a new image instead
            if (!want_filter && !in_first_row && cur_col >= image_span) start = 1'b1;
            value = (want_filter || start) ? pick_filter() : pick_data();
            send_word(value, start);
         end
      end
      steady_flow = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin : run_tests
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_filter_types();
      test_image_restart();
      test_mid_row_shrink();
      test_longest_row();
      test_random_streams();
      wait_drained();
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- png_scanline_unfilter.f -----
rtl/pngu_pkg.sv
rtl/pngu_ram.sv
rtl/pngu_recon.sv
rtl/png_scanline_unfilter.sv
rtl/pngu_checker.sv
sim/tb_png_scanline_unfilter.sv
